>>> rtl/core/pr80_pkg.sv
// ============================================================================
// pr80_pkg
// Shared types, constants and layer functions for the PRESENT-80 encrypt unit.
// ============================================================================
`default_nettype none

package pr80_pkg;

    localparam int BLOCK_W     = 64;
    localparam int KEY_W       = 80;
    localparam int KEY_UPPER_W = 16;
    localparam int ROUND_COUNT = 31;
    localparam int ROUND_W     = 5;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [ROUND_W-1:0] round_t;

    // Configuration register indexes.
    typedef enum logic {
        CFG_KEY_UPPER = 1'b0,
        CFG_KEY_LOWER = 1'b1
    } cfg_index_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
        4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    function automatic block_t sub_layer(input block_t s);
        block_t r;
        r = '0;
        for (int n = 0; n < 16; n++)
        begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    // Bit i moves to bit 16*(i mod 4) + i/4.
    function automatic block_t perm_layer(input block_t s);
        block_t r;
        r = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            r[(i % 4) * 16 + i / 4] = s[i];
        end
        return r;
    endfunction

    // Next key register: rotate left by 61, S-box on the top nibble,
    // round counter into bits 19..15.
    function automatic key_t key_update(input key_t k, input round_t rnd);
        key_t r;
        r = {k[18:0], k[79:19]};
        r[79:76] = SBOX[r[79:76]];
        r[19:15] = r[19:15] ^ rnd;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/present80_block_encrypt_unit.sv
// ============================================================================
// present80_block_encrypt_unit
// PRESENT-80 block encryption, fully unrolled into a round-per-stage pipeline.
// ============================================================================
// The unit takes one 64-bit plaintext request per cycle while in_stall is
// low and passes it through 31 round stages, each one register deep, and
// an output register holding the final key XOR. The 80-bit key schedule
// travels down the pipeline with each block, so the key registers are read
// only when a block enters. The whole pipeline advances together and holds
// when a finished result is stalled at the output. Keys must be written
// while no request is in flight; cfg_ready is always high.
`default_nettype none

module present80_block_encrypt_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire pr80_pkg::cfg_index_t  cfg_index,
    input  wire logic [63:0]           cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire pr80_pkg::block_t      plaintext,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output pr80_pkg::block_t           ciphertext
);
    import pr80_pkg::*;

    logic [KEY_UPPER_W-1:0] key_upper_reg;
    block_t                 key_lower_reg;

    logic   en;
    logic   stg_valid [ROUND_COUNT+1];
    block_t stg_state [ROUND_COUNT+1];
    key_t   stg_key   [ROUND_COUNT+1];

    logic   out_valid_reg;
    block_t ciphertext_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_UPPER: key_upper_reg <= cfg_data[KEY_UPPER_W-1:0];
                CFG_KEY_LOWER: key_lower_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The pipeline moves unless a finished result is waiting downstream.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    assign stg_valid[0] = in_valid;
    assign stg_state[0] = plaintext;
    assign stg_key[0]   = {key_upper_reg, key_lower_reg};

    for (genvar g = 0; g < ROUND_COUNT; g++)
    begin : g_round
        pr80_round_stage u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[g]),
            .in_state  (stg_state[g]),
            .in_key    (stg_key[g]),
            .round_num (ROUND_W'(g + 1)),
            .out_valid (stg_valid[g+1]),
            .out_state (stg_state[g+1]),
            .out_key   (stg_key[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stg_valid[ROUND_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ciphertext_reg <= stg_state[ROUND_COUNT] ^ stg_key[ROUND_COUNT][79:16];
        end
    end

    assign out_valid  = out_valid_reg;
    assign ciphertext = ciphertext_reg;

endmodule

`default_nettype wire

>>> rtl/core/pr80_round_stage.sv
// ============================================================================
// pr80_round_stage
// One registered PRESENT round: key XOR, S-box layer, bit permutation, and
// the matching key schedule step carried alongside the data.
// ============================================================================
`default_nettype none

module pr80_round_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire pr80_pkg::block_t in_state,
    input  wire pr80_pkg::key_t   in_key,
    input  wire pr80_pkg::round_t round_num,
    output logic                 out_valid,
    output pr80_pkg::block_t     out_state,
    output pr80_pkg::key_t       out_key
);
    import pr80_pkg::*;

    logic   valid_reg;
    block_t state_reg;
    block_t state_next;
    key_t   key_reg;
    key_t   key_next;

    always_comb
    begin
        state_next = perm_layer(sub_layer(in_state ^ in_key[79:16]));
        key_next   = key_update(in_key, round_num);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

`default_nettype wire

>>> tb/tb_present80_block_encrypt_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_present80_block_encrypt_unit
// Self-checking testbench for the PRESENT-80 block encryption unit.
// ============================================================================
// Plaintext requests go in through the valid/stall input channel under a
// range of keys. Each key is loaded through the configuration port while
// the unit is empty. A scoreboard class works out every ciphertext on its
// own and compares each result, in order, with the oldest expected block.
// Both channels insert random idle and stall cycles.

module tb_present80_block_encrypt_unit;

    import pr80_pkg::*;

    localparam logic [3:0] NIBBLE_SUB [16] = '{
        4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
        4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam int CIPHER_ROUNDS = 31;
    localparam int MAX_WAIT      = 14;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 205;

    class cipher_scoreboard;
        logic [15:0] key_hi = '0;
        logic [63:0] key_lo = '0;
        block_t      expected_q[$];
        int          errors = 0;

        function void write_key(cfg_index_t idx, logic [63:0] data);
            if (idx == CFG_KEY_UPPER)
                key_hi = data[15:0];
            else
                key_lo = data;
        endfunction

        function block_t cipher_of(block_t pt);
            logic [79:0] kreg;
            block_t      st;
            block_t      mixed;
            block_t      subbed;
            block_t      moved;
            kreg = {key_hi, key_lo};
            st   = pt;
            for (int rnd = 1; rnd <= CIPHER_ROUNDS; rnd++)
            begin
                mixed = st ^ kreg[79:16];
                for (int n = 0; n < 16; n++)
                    subbed[4*n +: 4] = NIBBLE_SUB[mixed[4*n +: 4]];
                // Bit b lands on bit 16*b mod 63; the top bit stays put.
                moved = '0;
                for (int b = 0; b < 63; b++)
                    moved[(b * 16) % 63] = subbed[b];
                moved[63] = subbed[63];
                st = moved;
                kreg = (kreg << 61) | (kreg >> 19);
                kreg[79:76] = NIBBLE_SUB[kreg[79:76]];
                kreg[19:15] = kreg[19:15] ^ 5'(rnd);
            end
            return st ^ kreg[79:16];
        endfunction

        function void note_request(block_t pt);
            expected_q.push_back(cipher_of(pt));
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(block_t ct);
            block_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected ciphertext %h", ct));
            end
            else
            begin
                want = expected_q.pop_front();
                if (ct !== want)
                    report($sformatf("ciphertext %h, expected %h", ct, want));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    block_t      plaintext;
    logic        out_valid;
    logic        out_stall;
    block_t      ciphertext;

    cipher_scoreboard board = new();
    bit in_eager  = 1'b0;
    bit out_eager = 1'b0;

    present80_block_encrypt_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait(bit eager);
        return eager ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic block_t rand_block();
        return {$urandom, $urandom};
    endfunction

    task automatic send_block(block_t pt);
        int gap;
        gap = draw_wait(in_eager);
        if ($urandom_range(0, 29) == 0)
            in_eager = !in_eager;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        plaintext <= pt;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(pt);
    endtask

    // Lets the pipeline empty out so the keys may be changed.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_key(cfg_index_t idx, logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        board.write_key(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_random_key();
        logic [63:0] hi_word;
        logic [63:0] lo_word;
        case ($urandom_range(0, 3))
            0:
            begin
                hi_word = '0;
                lo_word = '0;
            end
            1:
            begin
                hi_word = '1;
                lo_word = '1;
            end
            default:
            begin
                hi_word = {$urandom, $urandom};
                lo_word = {$urandom, $urandom};
            end
        endcase
        if ($urandom_range(0, 1))
        begin
            write_key(CFG_KEY_UPPER, hi_word);
            write_key(CFG_KEY_LOWER, lo_word);
        end
        else
        begin
            write_key(CFG_KEY_LOWER, lo_word);
            if ($urandom_range(0, 3) != 0)
                write_key(CFG_KEY_UPPER, hi_word);
        end
    endtask

    // Result side: a random stall before each ciphertext is taken.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = draw_wait(out_eager);
            if ($urandom_range(0, 29) == 0)
                out_eager = !out_eager;
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            board.check_result(ciphertext);
        end
    end

    initial
    begin
        block_t pt;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_KEY_UPPER;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        plaintext <= '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // The all-zero key straight out of reset.
        send_block('0);
        send_block('1);
        send_block(64'haaaa_aaaa_aaaa_aaaa);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'h8000_0000_0000_0001);
        send_block(64'h0123_4567_89ab_cdef);
        drain();

        // All-ones key; the bits above the upper key register are set too.
        write_key(CFG_KEY_UPPER, '1);
        write_key(CFG_KEY_LOWER, '1);
        send_block('0);
        send_block('1);
        send_block(64'hfedc_ba98_7654_3210);
        send_block(64'h0000_0001_0000_0000);
        send_block(64'h7fff_ffff_ffff_fffe);
        drain();

        // Only bits beyond the register width: the upper key must read zero.
        write_key(CFG_KEY_UPPER, 64'habcd_1234_5678_0000);
        write_key(CFG_KEY_LOWER, '0);
        send_block('0);
        send_block('1);
        drain();

        // Key bits that cross the two registers.
        write_key(CFG_KEY_UPPER, 64'h0000_0000_0000_8001);
        write_key(CFG_KEY_LOWER, 64'h8000_0000_0000_0001);
        send_block(64'h0f0f_0f0f_0f0f_0f0f);
        send_block(64'hf0f0_f0f0_f0f0_f0f0);
        send_block(rand_block());
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_random_key();
            in_eager = (phase % 3 == 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 9))
                    0: pt = rand_block() & rand_block() & rand_block();
                    1: pt = rand_block() | rand_block() | rand_block();
                    2: pt = 64'h1 << $urandom_range(0, 63);
                    default: pt = rand_block();
                endcase
                send_block(pt);
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pr80_pkg.sv
rtl/core/pr80_round_stage.sv
rtl/core/present80_block_encrypt_unit.sv
tb/tb_present80_block_encrypt_unit.sv
